FILE: sv/rbsd_pkg.sv
`timescale 1ns / 1ps

package rbsd_pkg;

    localparam int D_W    = 48;
    localparam int HALF_W = 24;
    localparam int PROD_W = 96;
    localparam int NUM_W  = 151;
    localparam int DEN_W  = 144;
    localparam int REM_W  = 50;
    localparam int Q_W    = 48;
    localparam int DIV_STEPS = 48;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_PARAM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_Z  = 3'd5;

    localparam logic [1:0] GRAV_SPHERICAL = 2'd0;

    localparam logic [D_W-1:0] GRAV_PARAM_RST = 48'd6687405709774;
    localparam logic [D_W-1:0] INERTIA_RST    = 48'd16777216;
    localparam logic [D_W-1:0] SAT_POS_MAG    = 48'h7FFF_FFFF_FFFF;
    localparam logic [D_W-1:0] SAT_NEG_MAG    = 48'h8000_0000_0000;

    typedef struct packed {
        logic [2:0][D_W-1:0] vel;
        logic [2:0][D_W-1:0] pmag;
        logic [2:0]          pneg;
        logic                pzero;
        logic [2:0][D_W-1:0] wmag;
        logic [2:0]          wneg;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [D_W-1:0]   root;
    } sqrt_t;

    function automatic logic [D_W-1:0] abs48(input logic [D_W-1:0] v);
        return v[D_W-1] ? (~v + 48'd1) : v;
    endfunction

    function automatic logic [D_W-1:0] sat48(input logic [Q_W-1:0] q, input logic ovf,
                                             input logic neg);
        logic [D_W-1:0] limit;
        logic [D_W-1:0] m;
        limit = neg ? SAT_NEG_MAG : SAT_POS_MAG;
        m = (ovf || (q > limit)) ? limit : q;
        return neg ? (~m + 48'd1) : m;
    endfunction

    function automatic sqrt_t sqrt_step(input logic [REM_W-1:0] rem,
                                        input logic [D_W-1:0] root, input logic [1:0] pair);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        sqrt_t r;
        t = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (t >= trial)
        begin
            t = t - trial;
            r.root = {root[D_W-2:0], 1'b1};
        end
        else
        begin
            r.root = {root[D_W-2:0], 1'b0};
        end
        r.rem = t[REM_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/rbsd_mul.sv
`timescale 1ns / 1ps

module rbsd_mul (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rbsd_pkg::D_W-1:0]    a,
    input  logic [rbsd_pkg::D_W-1:0]    b,
    output logic [rbsd_pkg::PROD_W-1:0] p
);
    import rbsd_pkg::*;

    logic [D_W-1:0]    pp_ll_reg;
    logic [D_W-1:0]    pp_lh_reg;
    logic [D_W-1:0]    pp_hl_reg;
    logic [D_W-1:0]    pp_hh_reg;
    logic [PROD_W-1:0] p_reg;

    // 24 x 24 partial products, then one summing stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= D_W'(a[HALF_W-1:0]) * D_W'(b[HALF_W-1:0]);
            pp_lh_reg <= D_W'(a[HALF_W-1:0]) * D_W'(b[D_W-1:HALF_W]);
            pp_hl_reg <= D_W'(a[D_W-1:HALF_W]) * D_W'(b[HALF_W-1:0]);
            pp_hh_reg <= D_W'(a[D_W-1:HALF_W]) * D_W'(b[D_W-1:HALF_W]);
            p_reg <= {48'd0, pp_ll_reg} + {24'd0, pp_lh_reg, 24'd0}
                   + {24'd0, pp_hl_reg, 24'd0} + {pp_hh_reg, 48'd0};
        end
    end

    assign p = p_reg;

endmodule

FILE: sv/rbsd_div.sv
`timescale 1ns / 1ps

module rbsd_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rbsd_pkg::NUM_W-1:0] num,
    input  logic [rbsd_pkg::DEN_W-1:0] den,
    output logic [rbsd_pkg::Q_W-1:0]   q,
    output logic                       ovf
);
    import rbsd_pkg::*;

    logic [DEN_W-1:0] rem_reg [0:DIV_STEPS-1];
    logic [DEN_W-1:0] den_reg [0:DIV_STEPS-1];
    logic [Q_W-1:0]   low_reg [0:DIV_STEPS-1];
    logic [Q_W-1:0]   q_reg   [0:DIV_STEPS];
    logic             ovf_reg [0:DIV_STEPS];

    // quotient wider than 48 bits, or divide by zero, saturates later
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {41'd0, num[NUM_W-1:Q_W]};
            den_reg[0] <= den;
            low_reg[0] <= num[Q_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({41'd0, num[NUM_W-1:Q_W]} >= den) && (num != '0);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        logic           qbit;

        // zero divisor keeps the quotient at zero, the overflow flag handles it
        always_comb
        begin
            t = {rem_reg[k], low_reg[k][Q_W-1]};
            qbit = (t >= {1'b0, den_reg[k]}) && (den_reg[k] != '0);
            d = qbit ? (t - {1'b0, den_reg[k]}) : t;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= {q_reg[k][Q_W-2:0], qbit};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < DIV_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= d[DEN_W-1:0];
                    den_reg[k+1] <= den_reg[k];
                    low_reg[k+1] <= {low_reg[k][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign q   = q_reg[DIV_STEPS];
    assign ovf = ovf_reg[DIV_STEPS];

endmodule

FILE: sv/rigid_body_state_derivative.sv
// throughput: one request per cycle while the output is not stalled; the square
// root (24 stages, two bits each) and the six 48-stage restoring dividers set
// the pipeline depth
// a stalled output freezes the whole pipeline until the result is taken
// reset clears all valid bits and loads the register defaults
`timescale 1ns / 1ps

module rigid_body_state_derivative (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbsd_pkg::D_W-1:0]       cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [47:0]             pos_x,
    input  logic signed [47:0]             pos_y,
    input  logic signed [47:0]             pos_z,
    input  logic signed [47:0]             vel_x,
    input  logic signed [47:0]             vel_y,
    input  logic signed [47:0]             vel_z,
    input  logic signed [47:0]             rate_x,
    input  logic signed [47:0]             rate_y,
    input  logic signed [47:0]             rate_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [47:0]             dpos_x,
    output logic signed [47:0]             dpos_y,
    output logic signed [47:0]             dpos_z,
    output logic signed [47:0]             acc_x,
    output logic signed [47:0]             acc_y,
    output logic signed [47:0]             acc_z,
    output logic signed [47:0]             ang_acc_x,
    output logic signed [47:0]             ang_acc_y,
    output logic signed [47:0]             ang_acc_z,
    output logic                           fault
);
    import rbsd_pkg::*;

    localparam int DEPTH      = 80;
    localparam int SQ_STAGES  = 24;
    localparam int ST_ROT_MUL = 25;
    localparam int ST_MULS    = 27;
    localparam int ST_LAST    = 79;

    logic [D_W-1:0] grav_param_reg;
    logic [1:0]     grav_mode_reg;
    logic           rot_en_reg;
    logic [D_W-1:0] inert_reg [0:2];

    logic             en;
    side_t            side_in;
    side_t            side_reg [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;
    logic             out_valid_reg;

    logic [PROD_W-1:0] sq_p [0:2];
    logic [PROD_W-1:0] sq_r2_reg   [0:SQ_STAGES];
    logic [D_W-1:0]    sq_root_reg [0:SQ_STAGES];
    logic [REM_W-1:0]  sq_rem_reg  [0:SQ_STAGES-1];

    logic [PROD_W-1:0] den_lo;
    logic [PROD_W-1:0] den_hi;
    logic [PROD_W-1:0] gnum_p [0:2];
    logic [PROD_W-1:0] rot_lo [0:2];
    logic [PROD_W-1:0] rot_hi [0:2];

    logic [NUM_W-1:0] dv_num_reg [0:5];
    logic [DEN_W-1:0] dv_den_reg [0:5];
    logic [Q_W-1:0]   dv_q   [0:5];
    logic             dv_ovf [0:5];

    logic [D_W-1:0] dpos_reg [0:2];
    logic [D_W-1:0] acc_reg  [0:2];
    logic [D_W-1:0] ang_reg  [0:2];
    logic           fault_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_param_reg <= GRAV_PARAM_RST;
            grav_mode_reg  <= GRAV_SPHERICAL;
            rot_en_reg     <= 1'b0;
            inert_reg[0]   <= INERTIA_RST;
            inert_reg[1]   <= INERTIA_RST;
            inert_reg[2]   <= INERTIA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRAV_PARAM: grav_param_reg <= cfg_data;
                REG_GRAV_MODE:  grav_mode_reg  <= cfg_data[1:0];
                REG_ROT_EN:     rot_en_reg     <= cfg_data[0];
                REG_INERTIA_X:  inert_reg[0]   <= cfg_data;
                REG_INERTIA_Y:  inert_reg[1]   <= cfg_data;
                REG_INERTIA_Z:  inert_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        side_in.vel[0]  = vel_x;
        side_in.vel[1]  = vel_y;
        side_in.vel[2]  = vel_z;
        side_in.pmag[0] = abs48(pos_x);
        side_in.pmag[1] = abs48(pos_y);
        side_in.pmag[2] = abs48(pos_z);
        side_in.pneg    = {pos_z[47], pos_y[47], pos_x[47]};
        side_in.pzero   = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
        side_in.wmag[0] = abs48(rate_x);
        side_in.wmag[1] = abs48(rate_y);
        side_in.wmag[2] = abs48(rate_z);
        side_in.wneg    = {rate_z[47], rate_y[47], rate_x[47]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // squared radius
    for (genvar i = 0; i < 3; i++)
    begin : g_sq
        rbsd_mul u_sq (
            .clk (clk),
            .en  (en),
            .a   (side_reg[0].pmag[i]),
            .b   (side_reg[0].pmag[i]),
            .p   (sq_p[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_r2_reg[0]   <= sq_p[0] + sq_p[1] + sq_p[2];
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    // integer square root, two result bits per stage
    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        sqrt_t s_a;
        sqrt_t s_b;

        always_comb
        begin
            s_a = sqrt_step(sq_rem_reg[k], sq_root_reg[k],
                            sq_r2_reg[k][PROD_W-1-4*k -: 2]);
            s_b = sqrt_step(s_a.rem, s_a.root, sq_r2_reg[k][PROD_W-3-4*k -: 2]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_r2_reg[k+1]   <= sq_r2_reg[k];
                sq_root_reg[k+1] <= s_b.root;
            end
        end

        if (k < SQ_STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[k+1] <= s_b.rem;
                end
            end
        end
    end

    // r^2 * |r| and mu * |p_i|
    rbsd_mul u_den_lo (
        .clk (clk),
        .en  (en),
        .a   (sq_r2_reg[SQ_STAGES][D_W-1:0]),
        .b   (sq_root_reg[SQ_STAGES]),
        .p   (den_lo)
    );

    rbsd_mul u_den_hi (
        .clk (clk),
        .en  (en),
        .a   (sq_r2_reg[SQ_STAGES][PROD_W-1:D_W]),
        .b   (sq_root_reg[SQ_STAGES]),
        .p   (den_hi)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_gnum
        rbsd_mul u_gnum (
            .clk (clk),
            .en  (en),
            .a   (side_reg[ST_MULS].pmag[i]),
            .b   (grav_param_reg),
            .p   (gnum_p[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_num_reg[i] <= {gnum_p[i][PROD_W-2:0], 56'd0};
                dv_den_reg[i] <= {48'd0, den_lo} + {den_hi, 48'd0};
            end
        end
    end

    // euler terms: |ia - ib| * |wa| * |wb| over iden * 2^32
    for (genvar i = 0; i < 3; i++)
    begin : g_rot
        localparam int IA = (i + 2) % 3;
        localparam int IB = (i + 1) % 3;
        localparam int WA = (i + 1) % 3;
        localparam int WB = (i + 2) % 3;

        logic [D_W-1:0]    di;
        logic [PROD_W-1:0] p1;

        assign di = (inert_reg[IA] > inert_reg[IB]) ? (inert_reg[IA] - inert_reg[IB])
                                                    : (inert_reg[IB] - inert_reg[IA]);

        rbsd_mul u_p1 (
            .clk (clk),
            .en  (en),
            .a   (di),
            .b   (side_reg[ST_ROT_MUL].wmag[WA]),
            .p   (p1)
        );

        rbsd_mul u_p2_lo (
            .clk (clk),
            .en  (en),
            .a   (p1[D_W-1:0]),
            .b   (side_reg[ST_MULS].wmag[WB]),
            .p   (rot_lo[i])
        );

        rbsd_mul u_p2_hi (
            .clk (clk),
            .en  (en),
            .a   (p1[PROD_W-1:D_W]),
            .b   (side_reg[ST_MULS].wmag[WB]),
            .p   (rot_hi[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_num_reg[3+i] <= {7'd0, ({48'd0, rot_lo[i]} + {rot_hi[i], 48'd0})};
                dv_den_reg[3+i] <= {64'd0, inert_reg[i], 32'd0};
            end
        end
    end

    for (genvar j = 0; j < 6; j++)
    begin : g_div
        rbsd_div u_div (
            .clk (clk),
            .en  (en),
            .num (dv_num_reg[j]),
            .den (dv_den_reg[j]),
            .q   (dv_q[j]),
            .ovf (dv_ovf[j])
        );
    end

    // result register
    for (genvar i = 0; i < 3; i++)
    begin : g_out
        localparam int IA = (i + 2) % 3;
        localparam int IB = (i + 1) % 3;
        localparam int WA = (i + 1) % 3;
        localparam int WB = (i + 2) % 3;

        logic rot_neg;
        logic grav_on;

        assign rot_neg = (inert_reg[IA] > inert_reg[IB]) ^ side_reg[ST_LAST].wneg[WA]
                       ^ side_reg[ST_LAST].wneg[WB];
        assign grav_on = (grav_mode_reg == GRAV_SPHERICAL) && !side_reg[ST_LAST].pzero;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dpos_reg[i] <= side_reg[ST_LAST].vel[i];
                acc_reg[i]  <= grav_on ? sat48(dv_q[i], dv_ovf[i], !side_reg[ST_LAST].pneg[i])
                                       : '0;
                ang_reg[i]  <= rot_en_reg ? sat48(dv_q[3+i], dv_ovf[3+i], rot_neg) : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fault_reg <= (grav_mode_reg == GRAV_SPHERICAL) && side_reg[ST_LAST].pzero;
        end
    end

    assign out_valid = out_valid_reg;
    assign dpos_x    = dpos_reg[0];
    assign dpos_y    = dpos_reg[1];
    assign dpos_z    = dpos_reg[2];
    assign acc_x     = acc_reg[0];
    assign acc_y     = acc_reg[1];
    assign acc_z     = acc_reg[2];
    assign ang_acc_x = ang_reg[0];
    assign ang_acc_y = ang_reg[1];
    assign ang_acc_z = ang_reg[2];
    assign fault     = fault_reg;

    a_fault_zero_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> acc_x == '0 && acc_y == '0 && acc_z == '0)
        else $error("fault with nonzero acceleration");

    a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> grav_mode_reg == GRAV_SPHERICAL)
        else $error("fault outside spherical gravity");

    a_no_grav: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grav_mode_reg != GRAV_SPHERICAL
        |-> acc_x == '0 && acc_y == '0 && acc_z == '0 && !fault)
        else $error("acceleration with gravity off");

    a_no_rot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rot_en_reg |-> ang_acc_x == '0 && ang_acc_y == '0 && ang_acc_z == '0)
        else $error("angular acceleration with rotation off");

endmodule

FILE: test/tb_rigid_body_state_derivative.sv
`timescale 1ns / 1ps

module tb_rigid_body_state_derivative;
    import rbsd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    typedef logic [9:0][47:0] deriv_t;
    typedef logic [2:0][47:0] vec3_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [D_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [47:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [47:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic signed [47:0] rate_x = '0, rate_y = '0, rate_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] dpos_x, dpos_y, dpos_z, acc_x, acc_y, acc_z;
    logic signed [47:0] ang_acc_x, ang_acc_y, ang_acc_z;
    logic fault;

    logic [47:0] mu_q;
    logic [1:0] mode_q;
    logic rot_q;
    logic [47:0] inertia_q [3];

    deriv_t pending_derivs [$];
    int errors = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;
    string field_names [10] = '{"dpos_x", "dpos_y", "dpos_z", "acc_x", "acc_y", "acc_z",
                                "ang_acc_x", "ang_acc_y", "ang_acc_z", "fault"};

    rigid_body_state_derivative i_dut (.*);

    always #1 clk = ~clk;

    function automatic logic [47:0] sat_quotient(logic [191:0] n, logic [191:0] d, bit neg);
        logic [191:0] q;
        logic [47:0] lim;
        logic [47:0] m;
        if (n == 0)
            return '0;
        q = (d == 0) ? '1 : n / d;
        lim = neg ? SAT_NEG_MAG : SAT_POS_MAG;
        m = (q > {144'd0, lim}) ? lim : q[47:0];
        return neg ? (~m + 48'd1) : m;
    endfunction

    function automatic logic [47:0] magnitude(logic [47:0] v);
        return v[47] ? (~v + 48'd1) : v;
    endfunction

    function automatic logic [47:0] euler_term(logic [47:0] ia, logic [47:0] ib,
                                               logic [47:0] iden, logic [47:0] wa,
                                               logic [47:0] wb);
        logic [191:0] n;
        logic [191:0] d;
        bit neg;
        n = 192'(ia > ib ? ia - ib : ib - ia) * 192'(magnitude(wa)) * 192'(magnitude(wb));
        d = 192'(iden) << 32;
        neg = (ia > ib) != (wa[47] != wb[47]);
        return sat_quotient(n, d, neg);
    endfunction

    function automatic deriv_t predict_derivative(vec3_t p, vec3_t v, vec3_t w);
        deriv_t r;
        logic [191:0] r2;
        logic [191:0] c2;
        logic [191:0] den;
        logic [47:0] root;
        logic [48:0] c;
        r = '0;
        for (int i = 0; i < 3; i++)
            r[i] = v[i];
        if (mode_q == GRAV_SPHERICAL)
        begin
            r2 = '0;
            for (int i = 0; i < 3; i++)
                r2 += 192'(magnitude(p[i])) * 192'(magnitude(p[i]));
            if (r2 == 0)
                r[9] = 48'd1;
            else
            begin
                root = '0;
                for (int b = 48; b >= 0; b--)
                begin
                    c = {1'b0, root} | (49'd1 << b);
                    c2 = 192'(c) * 192'(c);
                    if (c2 <= r2)
                        root = c[47:0];
                end
                den = r2 * 192'(root);
                for (int i = 0; i < 3; i++)
                    r[3 + i] = sat_quotient((192'(mu_q) * 192'(magnitude(p[i]))) << 56, den,
                                            !p[i][47]);
            end
        end
        if (rot_q)
        begin
            r[6] = euler_term(inertia_q[2], inertia_q[1], inertia_q[0], w[1], w[2]);
            r[7] = euler_term(inertia_q[0], inertia_q[2], inertia_q[1], w[2], w[0]);
            r[8] = euler_term(inertia_q[1], inertia_q[0], inertia_q[2], w[0], w[1]);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_GRAV_PARAM: mu_q = value;
            REG_GRAV_MODE:  mode_q = value[1:0];
            REG_ROT_EN:     rot_q = value[0];
            REG_INERTIA_X:  inertia_q[0] = value;
            REG_INERTIA_Y:  inertia_q[1] = value;
            REG_INERTIA_Z:  inertia_q[2] = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_derivs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_state(vec3_t p, vec3_t v, vec3_t w);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 33)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {pos_z, pos_y, pos_x} = p;
        {vel_z, vel_y, vel_x} = v;
        {rate_z, rate_y, rate_x} = w;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_derivs.push_back(predict_derivative(p, v, w));
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand_field();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = 48'h8000_0000_0000 + 48'($urandom_range(0, 2));
            1: v = 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 2));
            2: v = 48'($signed($urandom_range(0, 3)) - 1);
            3, 4:
            begin
                v = v >> $urandom_range(0, 47);
                if ($urandom_range(0, 1))
                    v = ~v + 48'd1;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [47:0] rand_moment();
        logic [47:0] v;
        v = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
        return (v == 0) ? 48'd1 : v;
    endfunction

    function automatic vec3_t rand_vec();
        vec3_t r;
        for (int i = 0; i < 3; i++)
            r[i] = rand_field();
        return r;
    endfunction

    task automatic test_translation();
        vec3_t z;
        vec3_t one_km;
        z = '0;
        one_km = {48'd0, 48'd0, 48'd16777216};
        send_state(z, z, z);
        send_state(one_km, {3{48'h7FFF_FFFF_FFFF}}, z);
        send_state({48'd0, 48'd16777216, 48'd0}, {3{48'h8000_0000_0000}}, z);
        send_state({3{48'h7FFF_FFFF_FFFF}}, z, {3{48'h7FFF_FFFF_FFFF}});
        send_state({3{48'h8000_0000_0000}}, {3{48'hFFFF_FFFF_FFFF}}, z);
        send_state({48'd1, 48'hFFFF_FFFF_FFFF, 48'd1}, z, z);
        send_state({48'd0, 48'd0, 48'd1}, z, z);
        send_state({48'd0, 48'd0, 48'h8000_0000_0000}, z, z);
        send_state({48'd107374182400, 48'd0, 48'd0}, one_km, z);
        end_stream();
        wait_idle();
    endtask

    task automatic test_rotation();
        vec3_t w;
        write_reg(REG_ROT_EN, 48'd1);
        write_reg(REG_INERTIA_X, 48'd16777216);
        write_reg(REG_INERTIA_Y, 48'd33554432);
        write_reg(REG_INERTIA_Z, 48'hFFFF_FFFF_FFFF);
        w = {48'd4294967296, 48'hFFFF_0000_0000, 48'd4294967296};
        send_state('0, '0, w);
        send_state('0, '0, {3{48'h7FFF_FFFF_FFFF}});
        send_state('0, '0, {3{48'h8000_0000_0000}});
        send_state('0, '0, {48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'd1});
        end_stream();
        wait_idle();
        write_reg(REG_INERTIA_X, 48'd1);
        write_reg(REG_INERTIA_Y, 48'd0);
        write_reg(REG_INERTIA_Z, 48'd0);
        send_state('0, '0, w);
        send_state('0, '0, {48'd0, 48'd5, 48'd7});
        send_state('0, '0, {3{48'h8000_0000_0000}});
        end_stream();
        wait_idle();
    endtask

    task automatic test_gravity_modes();
        vec3_t p;
        p = {48'd0, 48'hFFFF_FF00_0000, 48'd117440512};
        write_reg(REG_GRAV_PARAM, 48'd0);
        send_state(p, p, '0);
        send_state('0, p, '0);
        end_stream();
        wait_idle();
        write_reg(REG_GRAV_PARAM, 48'hFFFF_FFFF_FFFF);
        send_state(p, p, '0);
        send_state({48'd0, 48'd0, 48'd1}, p, '0);
        end_stream();
        wait_idle();
        write_reg(3'd6, 48'd123);
        write_reg(3'd7, 48'd0);
        for (int m = 1; m <= 3; m++)
        begin
            write_reg(REG_GRAV_MODE, 48'(m));
            send_state(p, p, '0);
            send_state('0, '0, '0);
            end_stream();
            wait_idle();
        end
        write_reg(REG_GRAV_MODE, 48'(GRAV_SPHERICAL));
        write_reg(REG_GRAV_PARAM, GRAV_PARAM_RST);
    endtask

    task automatic test_random_states();
        logic [47:0] moment;
        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase == 3);
            write_reg(REG_GRAV_PARAM, $urandom_range(0, 3) == 0 ? 48'hFFFF_FFFF_FFFF
                                                                  : rand_moment());
            write_reg(REG_GRAV_MODE, $urandom_range(0, 4) == 0 ? 48'($urandom_range(1, 3))
                                                               : 48'(GRAV_SPHERICAL));
            write_reg(REG_ROT_EN, 48'($urandom_range(0, 3) != 0));
            moment = rand_moment();
            write_reg(REG_INERTIA_X, $urandom_range(0, 2) == 0 ? moment : rand_moment());
            write_reg(REG_INERTIA_Y, $urandom_range(0, 2) == 0 ? moment : rand_moment());
            write_reg(REG_INERTIA_Z, $urandom_range(0, 5) == 0 ? INERTIA_RST : rand_moment());
            for (int n = 0; n < 210; n++)
                send_state(rand_vec(), rand_vec(), rand_vec());
            end_stream();
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= (!no_idle && $urandom_range(0, 99) < 33);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            deriv_t got;
            deriv_t want;
            got = {47'd0, fault, ang_acc_z, ang_acc_y, ang_acc_x, acc_z, acc_y, acc_x,
                   dpos_z, dpos_y, dpos_x};
            if (pending_derivs.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_derivs.pop_front();
                for (int i = 0; i < 10; i++)
                    if (got[i] !== want[i])
                        report_mismatch(field_names[i], got[i], want[i]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[rigid_body_state_derivative] ERROR");
            $finish;
        end
    end

    initial
    begin
        mu_q = GRAV_PARAM_RST;
        mode_q = GRAV_SPHERICAL;
        rot_q = 1'b0;
        for (int i = 0; i < 3; i++)
            inertia_q[i] = INERTIA_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_translation();
        test_rotation();
        test_gravity_modes();
        test_random_states();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[rigid_body_state_derivative] OK");
        else
            $display("[rigid_body_state_derivative] ERROR");
        $finish;
    end

endmodule
